// ===== design/qoicd_pkg.sv =====
// Shared types, constants and the index hash for the QOI chunk decoder.
package qoicd_pkg;

  localparam int TOTAL_W = 29;
  localparam int RUN_W   = 6;
  localparam int IDX_W   = 6;

  localparam logic [7:0] OP_RGB  = 8'hFE;
  localparam logic [7:0] OP_RGBA = 8'hFF;

  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } px_t;

  localparam px_t PX_RESET = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

  // Request from the chunk decoder to the pixel emitter.
  typedef struct packed {
    logic             start;
    px_t              pix;
    logic [RUN_W-1:0] count;
  } emit_cmd_t;

  typedef struct packed {
    logic busy;
    logic complete;
  } emit_stat_t;

  // Index slot (r*3 + g*5 + b*7 + a*11) mod 64; only the low six bits of each term matter.
  function automatic logic [IDX_W-1:0] px_hash(input px_t p);
    logic [IDX_W-1:0] s;
    s = p.r[IDX_W-1:0] * 6'd3 + p.g[IDX_W-1:0] * 6'd5 + p.b[IDX_W-1:0] * 6'd7
      + p.a[IDX_W-1:0] * 6'd11;
    return s;
  endfunction

endpackage

// ===== design/qoi_chunk_decoder.sv =====
// A pixel-producing byte is registered on acceptance, decoded in S_EXEC, then written to the index
// and handed to the emitter in S_WRITE; the emitter repeats it one pixel per cycle while out_stall is low.
// A new byte is accepted only in S_IDLE and once the emitter has finished the previous run.
// Index reads are issued at acceptance and return from the index memory in the following cycle.
// Reset (synchronous, active low) clears control state and all index valid bits, and sets
// pixel_total to 1; a start request clears the index, the pixel and the pixel count.
module qoi_chunk_decoder #(
  parameter int unsigned COUNT_LIMIT = 400000000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [qoicd_pkg::TOTAL_W-1:0]  cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [7:0]                     in_byte_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_alpha,
  output logic                           out_last_of_run,
  output logic                           out_image_done
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WRITE} state_t;
  typedef enum logic [1:0] {K_NONE, K_LUMA, K_RGB, K_RGBA} kind_t;

  state_t                          state_r, state_nxt;
  kind_t                           kind_r, kind_nxt;
  logic [2:0]                      pend_cnt_r, pend_cnt_nxt;
  logic [31:0]                     held_r, held_nxt;
  qoicd_pkg::px_t                  pix_r, pix_nxt;
  logic [qoicd_pkg::RUN_W-1:0]     run_cnt_r, run_cnt_nxt;
  logic [7:0]                      byte_r;
  logic [qoicd_pkg::TOTAL_W-1:0]   pixel_total_r;
  logic [qoicd_pkg::TOTAL_W-1:0]   total_eff;
  logic                            in_acc;
  logic                            clear_img;
  qoicd_pkg::px_t                  idx_rd_data;
  logic                            idx_wr_en;
  qoicd_pkg::emit_cmd_t            emit_cmd;
  qoicd_pkg::emit_stat_t           emit_st;
  logic [31:0]                     shifted;
  logic [2:0]                      cnt_inc;
  logic [5:0]                      vg;

  assign total_eff = (pixel_total_r > qoicd_pkg::TOTAL_W'(COUNT_LIMIT))
                   ? qoicd_pkg::TOTAL_W'(COUNT_LIMIT) : pixel_total_r;

  assign in_stall  = (state_r != S_IDLE) || emit_st.busy;
  assign in_acc    = in_valid && !in_stall;
  assign clear_img = in_acc && in_op;

  assign shifted = {held_r[23:0], byte_r};
  assign cnt_inc = pend_cnt_r + 1'b1;
  assign vg      = held_r[5:0];

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    pend_cnt_nxt = pend_cnt_r;
    held_nxt     = held_r;
    pix_nxt      = pix_r;
    run_cnt_nxt  = run_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (clear_img) begin
          kind_nxt     = K_NONE;
          pend_cnt_nxt = '0;
          held_nxt     = '0;
          pix_nxt      = qoicd_pkg::PX_RESET;
        end else if (in_acc && !emit_st.complete) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt   = S_IDLE;
        run_cnt_nxt = qoicd_pkg::RUN_W'(1);
        case (kind_r)
          K_LUMA: begin
            pix_nxt.r    = pix_r.r + 8'(vg) + 8'(byte_r[7:4]) - 8'd40;
            pix_nxt.g    = pix_r.g + 8'(vg) - 8'd32;
            pix_nxt.b    = pix_r.b + 8'(vg) + 8'(byte_r[3:0]) - 8'd40;
            kind_nxt     = K_NONE;
            pend_cnt_nxt = '0;
            held_nxt     = '0;
            state_nxt    = S_WRITE;
          end
          K_RGB, K_RGBA: begin
            if ((kind_r == K_RGB && cnt_inc == 3'd3) || (kind_r == K_RGBA && cnt_inc == 3'd4)) begin
              if (kind_r == K_RGB) begin
                pix_nxt = {shifted[23:0], pix_r.a};
              end else begin
                pix_nxt = shifted;
              end
              kind_nxt     = K_NONE;
              pend_cnt_nxt = '0;
              held_nxt     = '0;
              state_nxt    = S_WRITE;
            end else begin
              held_nxt     = shifted;
              pend_cnt_nxt = cnt_inc;
            end
          end
          default: begin
            if (byte_r == qoicd_pkg::OP_RGB) begin
              kind_nxt     = K_RGB;
              pend_cnt_nxt = '0;
              held_nxt     = '0;
            end else if (byte_r == qoicd_pkg::OP_RGBA) begin
              kind_nxt     = K_RGBA;
              pend_cnt_nxt = '0;
              held_nxt     = '0;
            end else begin
              case (byte_r[7:6])
                qoicd_pkg::TAG_INDEX: begin
                  pix_nxt   = idx_rd_data;
                  state_nxt = S_WRITE;
                end
                qoicd_pkg::TAG_DIFF: begin
                  pix_nxt.r = pix_r.r + 8'(byte_r[5:4]) - 8'd2;
                  pix_nxt.g = pix_r.g + 8'(byte_r[3:2]) - 8'd2;
                  pix_nxt.b = pix_r.b + 8'(byte_r[1:0]) - 8'd2;
                  state_nxt = S_WRITE;
                end
                qoicd_pkg::TAG_LUMA: begin
                  kind_nxt     = K_LUMA;
                  pend_cnt_nxt = '0;
                  held_nxt     = 32'(byte_r);
                end
                qoicd_pkg::TAG_RUN: begin
                  run_cnt_nxt = byte_r[5:0] + 1'b1;
                  state_nxt   = S_WRITE;
                end
                default: begin
                  state_nxt = S_IDLE;
                end
              endcase
            end
          end
        endcase
      end
      S_WRITE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      kind_r        <= K_NONE;
      pend_cnt_r    <= '0;
      held_r        <= '0;
      pix_r         <= qoicd_pkg::PX_RESET;
      run_cnt_r     <= '0;
      pixel_total_r <= qoicd_pkg::TOTAL_W'(1);
    end else begin
      state_r    <= state_nxt;
      kind_r     <= kind_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      held_r     <= held_nxt;
      pix_r      <= pix_nxt;
      run_cnt_r  <= run_cnt_nxt;
      if (cfg_wr_en) begin
        pixel_total_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_byte_value;
    end
  end

  // The new pixel is written to the index and handed to the emitter in the same cycle.
  assign idx_wr_en      = (state_r == S_WRITE);
  assign emit_cmd.start = idx_wr_en;
  assign emit_cmd.pix   = pix_r;
  assign emit_cmd.count = run_cnt_r;

  qoicd_index_mem u_index (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (clear_img),
    .rd_en   (in_acc),
    .rd_addr (in_byte_value[qoicd_pkg::IDX_W-1:0]),
    .rd_data (idx_rd_data),
    .wr_en   (idx_wr_en),
    .wr_addr (qoicd_pkg::px_hash(pix_r)),
    .wr_data (pix_r)
  );

  qoicd_emitter u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .clear           (clear_img),
    .total           (total_eff),
    .cmd             (emit_cmd),
    .stat            (emit_st),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_last_of_run (out_last_of_run),
    .out_image_done  (out_image_done)
  );

  a_cmd_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> !emit_st.busy)
    else $error("emitter request issued while a run is still in progress");

  a_cmd_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> emit_st.busy)
    else $error("emitter request did not start a run");

  a_no_run_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    emit_st.complete |-> !emit_st.busy)
    else $error("emitter still busy after the image's last pixel");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_image_done) |-> out_last_of_run)
    else $error("image's last pixel not flagged as last of its run");

endmodule

// ===== design/qoicd_index_mem.sv =====
// Color index: 64-entry synchronous memory with per-entry valid bits.
module qoicd_index_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         rd_en,
  input  logic [qoicd_pkg::IDX_W-1:0]  rd_addr,
  output qoicd_pkg::px_t               rd_data,
  input  logic                         wr_en,
  input  logic [qoicd_pkg::IDX_W-1:0]  wr_addr,
  input  qoicd_pkg::px_t               wr_data
);

  localparam int DEPTH = 1 << qoicd_pkg::IDX_W;

  qoicd_pkg::px_t    mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  qoicd_pkg::px_t    rd_data_r;
  logic              rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Entries never written since the last clear read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== design/qoicd_emitter.sv =====
// Pixel emitter: repeats a pixel for a run, counts pixels and holds the output register.
module qoicd_emitter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clear,
  input  logic [qoicd_pkg::TOTAL_W-1:0]  total,
  input  qoicd_pkg::emit_cmd_t           cmd,
  output qoicd_pkg::emit_stat_t          stat,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_alpha,
  output logic                           out_last_of_run,
  output logic                           out_image_done
);

  qoicd_pkg::px_t                   pix_r;
  logic [qoicd_pkg::RUN_W-1:0]      run_left_r;
  logic [qoicd_pkg::TOTAL_W-1:0]    emitted_r;
  logic                             out_valid_r;
  qoicd_pkg::px_t                   out_pix_r;
  logic                             out_last_r;
  logic                             out_done_r;
  logic                             load;
  logic                             at_end;
  logic [qoicd_pkg::TOTAL_W-1:0]    emitted_inc;

  assign emitted_inc = emitted_r + 1'b1;
  assign at_end      = (emitted_inc == total);
  assign load        = (run_left_r != '0) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_left_r  <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        pix_r      <= cmd.pix;
        run_left_r <= cmd.count;
      end else if (load) begin
        // A run that reaches the end of the image is cut short here.
        run_left_r <= at_end ? '0 : run_left_r - 1'b1;
      end
      if (clear) begin
        emitted_r <= '0;
      end else if (load) begin
        emitted_r <= emitted_inc;
      end
      if (load) begin
        out_valid_r <= 1'b1;
        out_pix_r   <= pix_r;
        out_last_r  <= (run_left_r == 1) || at_end;
        out_done_r  <= at_end;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.busy     = (run_left_r != '0);
  assign stat.complete = (emitted_r >= total);

  assign out_valid       = out_valid_r;
  assign out_red         = out_pix_r.r;
  assign out_green       = out_pix_r.g;
  assign out_blue        = out_pix_r.b;
  assign out_alpha       = out_pix_r.a;
  assign out_last_of_run = out_last_r;
  assign out_image_done  = out_done_r;

endmodule
